>>> rtl/bss_pkg.sv
// Shared types, constants and helpers for the boundary segment splitter.
// No dependencies; imported by the interfaces and all rtl modules.
package bss_pkg;

    localparam int MAX_BOUNDARY = 16;
    localparam int FILL_W       = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam int LEN_W        = 5;
    localparam int CNT_W        = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int BND_W        = 2 * CFG_DATA_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BND_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BND_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BND_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG = 2'd3;

    // result kinds
    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef logic [7:0]        t_byte;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [LEN_W-1:0]  t_len;

    localparam t_len   LEN_RESET = t_len'(1);
    localparam t_len   LEN_MAX   = t_len'(MAX_BOUNDARY);
    localparam t_count CNT_MAX   = '1;

    // window status handed from the cell row to the segment control
    typedef struct packed {
        logic  match;
        t_byte oldest;
    } t_win_stat;

    // boundary length minus one, zero treated as one, clamped to the row size
    function automatic t_fill eff_len_m1(t_len len);
        t_fill res;
        if (len == '0) begin
            res = '0;
        end else if (len > LEN_MAX) begin
            res = t_fill'(MAX_BOUNDARY - 1);
        end else begin
            res = t_fill'(len - 1'b1);
        end
        return res;
    endfunction

endpackage

>>> rtl/bss_in_if.sv
// Input byte channel of the boundary segment splitter.
// Depends on bss_pkg.
interface bss_in_if import bss_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/bss_out_if.sv
// Result channel of the boundary segment splitter: content bytes and end markers.
// Depends on bss_pkg.
interface bss_out_if import bss_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   kind_out;
    t_byte  content_byte;
    t_count segment_length;
    logic   overflowed;

    modport source (output valid, output kind_out, output content_byte,
                    output segment_length, output overflowed, input ready);
    modport sink   (input valid, input kind_out, input content_byte,
                    input segment_length, input overflowed, output ready);
endinterface

>>> rtl/bss_cell.sv
// One window cell: holds a byte, passes it on, compares the byte arriving
// at its position with its boundary byte. Depends on bss_pkg.
module bss_cell import bss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_prev,
    input  t_byte i_pat,
    input  logic  i_care,
    output t_byte o_byte,
    output logic  o_eq
);

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_prev;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = !i_care || (i_prev == i_pat);

endmodule

>>> rtl/bss_window.sv
// Row of window cells: newest byte enters cell 0, each cell hands its byte
// to the next. Reports the full-window match and the oldest byte.
// Depends on bss_pkg and bss_cell.
module bss_window import bss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_shift,
    input  t_byte            i_data,
    input  logic [BND_W-1:0] i_bnd,
    input  t_fill            i_len_m1,
    output t_win_stat        o_stat
);

    t_byte                   w_bnd_b [MAX_BOUNDARY];
    t_byte                   w_prev  [MAX_BOUNDARY];
    t_byte                   w_byte  [MAX_BOUNDARY];
    logic [MAX_BOUNDARY-1:0] w_eq;

    for (genvar g = 0; g < MAX_BOUNDARY; g++) begin : g_cell
        t_fill w_pidx;
        logic  w_care;

        assign w_bnd_b[g] = i_bnd[8*g +: 8];

        if (g == 0) begin : g_head
            assign w_prev[g] = i_data;
        end else begin : g_link
            assign w_prev[g] = w_byte[g-1];
        end

        // cell g sees the byte g steps back, which lines up with
        // boundary byte len-1-g
        assign w_care = (t_fill'(g) <= i_len_m1);
        assign w_pidx = i_len_m1 - t_fill'(g);

        bss_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(i_shift),
            .i_prev (w_prev[g]),
            .i_pat  (w_bnd_b[w_pidx]),
            .i_care (w_care),
            .o_byte (w_byte[g]),
            .o_eq   (w_eq[g])
        );
    end

    assign o_stat.match  = &w_eq;
    assign o_stat.oldest = w_prev[i_len_m1];

endmodule

>>> rtl/boundary_segment_splitter.sv
// Top level of the boundary segment splitter.
// Depends on bss_pkg, bss_in_if, bss_out_if and bss_window.
//
// Usage:
//   i_in carries one raw byte per transfer. o_out carries one result per
//   transfer: a content byte (kind_out 0) or a segment end marker (kind_out 1)
//   with the saturating segment length and the overflow flag.
//   The configured boundary (1..16 bytes) is stripped from the stream.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   write it only while the block is idle. Writing boundary bytes or length
//   discards the bytes held in the window.
// Timing:
//   One byte is taken every cycle unless o_out stalls. A result appears on
//   o_out the cycle after the byte that causes it; the compare across the
//   cell row is combinational and registers with the segment counter update.
//   A held byte leaves once boundary_length - 1 newer bytes sit behind it.
// Reset clears the window fill, the segment counter and the output valid flag,
// and loads the default configuration (length 1, limit at the counter maximum).
// When the receiver stalls, the output register holds its result and i_in
// is held off until it drains; nothing is lost.
module boundary_segment_splitter import bss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bss_in_if.sink                i_in,
    bss_out_if.source             o_out
);

    // configuration
    logic [CFG_DATA_W-1:0] r_bnd_lo, n_bnd_lo;
    logic [CFG_DATA_W-1:0] r_bnd_hi, n_bnd_hi;
    t_len                  r_len, n_len;
    t_count                r_max, n_max;

    // segment state
    t_fill  r_fill, n_fill;
    t_count r_count, n_count;
    logic   r_ovf, n_ovf;

    // output register
    logic   r_out_valid, n_out_valid;
    logic   r_kind, n_kind;
    t_byte  r_byte, n_byte;
    t_count r_seg, n_seg;
    logic   r_oflag, n_oflag;

    logic      w_in_xfer;
    logic      w_full;
    t_fill     w_len_m1;
    t_win_stat w_stat;

    assign w_len_m1  = eff_len_m1(r_len);
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer = i_in.valid && i_in.ready;
    assign w_full    = (r_fill >= w_len_m1);

    bss_window u_window (
        .i_clk   (i_clk),
        .i_shift (w_in_xfer),
        .i_data  (i_in.data_byte),
        .i_bnd   ({r_bnd_hi, r_bnd_lo}),
        .i_len_m1(w_len_m1),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_bnd_lo    = r_bnd_lo;
        n_bnd_hi    = r_bnd_hi;
        n_len       = r_len;
        n_max       = r_max;
        n_fill      = r_fill;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_seg       = r_seg;
        n_oflag     = r_oflag;

        if (w_in_xfer) begin
            if (!w_full) begin
                n_fill = r_fill + 1'b1;
            end else if (w_stat.match) begin
                n_out_valid = 1'b1;
                n_kind      = KIND_END;
                n_byte      = '0;
                n_seg       = r_count;
                n_oflag     = r_ovf;
                n_fill      = '0;
                n_count     = '0;
                n_ovf       = 1'b0;
            end else begin
                n_fill = w_len_m1;
                if (r_count != CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                if (r_count >= r_max) begin
                    // past the limit: counted, not passed on
                    n_ovf = 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CONTENT;
                    n_byte      = w_stat.oldest;
                    n_seg       = '0;
                    n_oflag     = 1'b0;
                end
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BND_LO: begin
                    n_bnd_lo = i_cfg_data;
                    n_fill   = '0;
                end
                REG_BND_HI: begin
                    n_bnd_hi = i_cfg_data;
                    n_fill   = '0;
                end
                REG_BND_LEN: begin
                    n_len  = i_cfg_data[LEN_W-1:0];
                    n_fill = '0;
                end
                REG_MAX_SEG: begin
                    n_max = i_cfg_data[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_lo    <= '0;
            r_bnd_hi    <= '0;
            r_len       <= LEN_RESET;
            r_max       <= CNT_MAX;
            r_fill      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bnd_lo    <= n_bnd_lo;
            r_bnd_hi    <= n_bnd_hi;
            r_len       <= n_len;
            r_max       <= n_max;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_seg   <= n_seg;
        r_oflag <= n_oflag;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind_out       = r_kind;
    assign o_out.content_byte   = r_byte;
    assign o_out.segment_length = r_seg;
    assign o_out.overflowed     = r_oflag;

    // the window never holds a full boundary between transfers
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_len_m1)
        else $error("window fill reached boundary length");

    // a boundary match clears the segment state
    a_match_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_full && w_stat.match)
        |=> (r_fill == '0 && r_count == '0 && !r_ovf))
        else $error("segment state not cleared after boundary");

    // overflow can only be flagged once bytes have been counted
    a_ovf_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count != '0))
        else $error("overflow flag set with empty segment");

endmodule
